[sv/assert_macros.svh]
// Assertion macros shared by the edge detector RTL.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/rgm_pkg.sv]
// Shared constants and types for the Roberts cross edge detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rgm_pkg;

  localparam int LINE_WIDTH   = 256;
  localparam int FRAME_HEIGHT = 256;

  localparam int COL_W = $clog2(LINE_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);

  localparam int PIX_W  = 8;
  localparam int DIFF_W = PIX_W + 1;
  localparam int SQ_W   = 2 * PIX_W;
  localparam int SUM_W  = SQ_W + 1;

  // The radicand has this many fraction bits, so the root has half as many.
  localparam int FRAC_W = 16;
  localparam int RAD_W  = 2 * ((SUM_W + FRAC_W + 1) / 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  localparam int GAIN_W = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  localparam int PROD_W = GAIN_W + ROOT_W;
  localparam int EDGE_W = 8;
  localparam logic [EDGE_W-1:0] EDGE_MAX = EDGE_W'(255);

  // One word moving along the square root chain.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic              last;
  } sqrt_word_t;

endpackage

`default_nettype wire

[sv/rgm_front.sv]
// Front end: position counters, line store, neighbor pixels and the
// sum of squared Roberts differences. Depends on rgm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rgm_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [rgm_pkg::PIX_W-1:0] pixel,
  input  wire logic                frame_start,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rgm_pkg::sqrt_word_t      out_word
);

  logic [rgm_pkg::PIX_W-1:0] line_mem [rgm_pkg::LINE_WIDTH];
  logic [rgm_pkg::PIX_W-1:0] above;
  logic [rgm_pkg::PIX_W-1:0] left_pixel;
  logic [rgm_pkg::COL_W-1:0] col;
  logic [rgm_pkg::ROW_W-1:0] row;

  logic                             s0_valid;
  logic signed [rgm_pkg::DIFF_W-1:0] s0_gx;
  logic [rgm_pkg::PIX_W-1:0]        s0_left;
  logic                             s0_end;

  logic                s1_valid;
  rgm_pkg::sqrt_word_t s1_word;

  logic                      acc;
  logic                      s0_ready_in;
  logic                      s1_ready_in;
  logic [rgm_pkg::COL_W-1:0] col_eff;
  logic [rgm_pkg::ROW_W-1:0] row_eff;
  logic                      produce;
  logic                      at_end;
  logic                      col_wrap;
  logic signed [rgm_pkg::DIFF_W-1:0]   gx_c;
  logic signed [rgm_pkg::DIFF_W-1:0]   gy_c;
  logic signed [2*rgm_pkg::DIFF_W-1:0] sq_x;
  logic signed [2*rgm_pkg::DIFF_W-1:0] sq_y;
  logic [rgm_pkg::SUM_W-1:0]           sum_c;

  assign s1_ready_in = !s1_valid || out_ready;
  assign s0_ready_in = !s0_valid || s1_ready_in;
  assign in_ready    = s0_ready_in;
  assign acc         = in_valid && in_ready;

  assign col_eff  = frame_start ? '0 : col;
  assign row_eff  = frame_start ? '0 : row;
  assign produce  = (row_eff >= rgm_pkg::ROW_W'(2)) && (col_eff >= rgm_pkg::COL_W'(2));
  assign col_wrap = (col_eff == rgm_pkg::COL_W'(rgm_pkg::LINE_WIDTH - 1));
  assign at_end   = (row_eff == rgm_pkg::ROW_W'(rgm_pkg::FRAME_HEIGHT - 1)) && col_wrap;

  // The registered read of the line store holds the pixel above the word
  // that was accepted last, which is the upper-left pixel of the next one.
  assign gx_c = $signed({1'b0, above}) - $signed({1'b0, pixel});
  assign gy_c = $signed({1'b0, above}) - $signed({1'b0, s0_left});
  assign sq_x = s0_gx * s0_gx;
  assign sq_y = gy_c * gy_c;
  assign sum_c = rgm_pkg::SUM_W'(sq_x[rgm_pkg::SQ_W-1:0])
               + rgm_pkg::SUM_W'(sq_y[rgm_pkg::SQ_W-1:0]);

  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[col_eff] <= pixel;
      above             <= line_mem[col_eff];
      left_pixel        <= pixel;
      s0_gx             <= gx_c;
      s0_left           <= left_pixel;
      s0_end            <= at_end;
    end
    if (s1_ready_in && s0_valid) begin
      s1_word.rem  <= '0;
      s1_word.root <= '0;
      s1_word.rad  <= rgm_pkg::RAD_W'({sum_c, {rgm_pkg::FRAC_W{1'b0}}});
      s1_word.last <= s0_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (acc) begin
        col      <= col_wrap ? '0 : col_eff + rgm_pkg::COL_W'(1);
        s0_valid <= produce;
        if (col_wrap) begin
          row <= (row_eff == rgm_pkg::ROW_W'(rgm_pkg::FRAME_HEIGHT - 1)) ?
                 '0 : row_eff + rgm_pkg::ROW_W'(1);
        end else begin
          row <= row_eff;
        end
      end else if (s1_ready_in) begin
        s0_valid <= 1'b0;
      end
      if (s1_ready_in) begin
        s1_valid <= s0_valid;
      end
    end
  end

  assign out_valid = s1_valid;
  assign out_word  = s1_word;

  `ASSERT_NEXT(a_interior_loads, clk, rst, acc && produce, s0_valid)
  `ASSERT_NEXT(a_start_restarts_col, clk, rst, acc && frame_start, col == rgm_pkg::COL_W'(1))
  `ASSERT_IMPL(a_stall_only_when_full, clk, rst, !in_ready, s0_valid && s1_valid && !out_ready)

endmodule

`default_nettype wire

[sv/rgm_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per word.
// Depends on rgm_pkg.
`default_nettype none

module rgm_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rgm_pkg::sqrt_word_t in_word,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rgm_pkg::sqrt_word_t out_word
);

  logic                      valid_q;
  rgm_pkg::sqrt_word_t       word_q;
  rgm_pkg::sqrt_word_t       word_next;
  logic [rgm_pkg::REM_W-1:0] rem_sh;
  logic [rgm_pkg::REM_W-1:0] trial;

  // Bring down the next two radicand bits and try a one in this root bit.
  assign rem_sh = {in_word.rem[rgm_pkg::REM_W-3:0],
                   in_word.rad[rgm_pkg::RAD_W-1:rgm_pkg::RAD_W-2]};
  assign trial  = rgm_pkg::REM_W'({in_word.root, 2'b01});

  always_comb begin
    word_next      = in_word;
    word_next.rad  = {in_word.rad[rgm_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      word_next.rem  = rem_sh - trial;
      word_next.root = {in_word.root[rgm_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      word_next.rem  = rem_sh;
      word_next.root = {in_word.root[rgm_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  assign in_ready = !valid_q || out_ready;

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_q <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  assign out_valid = valid_q;
  assign out_word  = word_q;

endmodule

`default_nettype wire

[sv/rgm_scale.sv]
// Gain stage: multiplies the magnitude by the 8.8 gain and saturates to
// eight bits. Depends on rgm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rgm_scale (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rgm_pkg::sqrt_word_t  in_word,
  input  wire logic [rgm_pkg::GAIN_W-1:0] gain,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [rgm_pkg::EDGE_W-1:0] edge_value,
  output logic                      frame_end
);

  logic                       p_valid;
  logic [rgm_pkg::PROD_W-1:0] p_prod;
  logic                       p_last;
  logic                       o_valid;
  logic [rgm_pkg::EDGE_W-1:0] o_edge;
  logic                       o_last;

  logic                       o_ready_in;
  logic [rgm_pkg::EDGE_W-1:0] edge_c;

  assign o_ready_in = !o_valid || out_ready;
  assign in_ready   = !p_valid || o_ready_in;

  // Anything at or above 256 after dropping the fraction saturates.
  assign edge_c = (|p_prod[rgm_pkg::PROD_W-1:rgm_pkg::FRAC_W+rgm_pkg::EDGE_W]) ?
                  rgm_pkg::EDGE_MAX :
                  p_prod[rgm_pkg::FRAC_W+rgm_pkg::EDGE_W-1:rgm_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_prod <= rgm_pkg::PROD_W'(gain) * rgm_pkg::PROD_W'(in_word.root);
      p_last <= in_word.last;
    end
    if (o_ready_in && p_valid) begin
      o_edge <= edge_c;
      o_last <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid <= in_valid;
      end
      if (o_ready_in) begin
        o_valid <= p_valid;
      end
    end
  end

  assign out_valid  = o_valid;
  assign edge_value = o_edge;
  assign frame_end  = o_last;

  `ASSERT_NEXT(a_product_held, clk, rst, p_valid && !o_ready_in, p_valid && $stable(p_prod))

endmodule

`default_nettype wire

[sv/roberts_gradient_magnitude_top.sv]
// Roberts cross edge detector: top level. Depends on rgm_pkg, rgm_front,
// rgm_sqrt_cell and rgm_scale.
`default_nettype none

// Pixels enter in raster order, one per clock when out_ready stays high, and
// each interior pixel yields one word on the output after its lower-right
// neighbor was taken, through two front stages (line store read, then squares
// and sum), one cell per root bit of the 17-bit magnitude, then the gain
// product and the saturating output register. Most of the latency is in the
// square root chain; throughput is one pixel per clock without output stalls.
// Border pixels give no output. A stall on the output backs up stage by stage,
// so the input keeps taking pixels while empty stages remain. The line store
// needs no clearing after reset. Write gain only while the block is idle.
module roberts_gradient_magnitude_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [rgm_pkg::GAIN_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rgm_pkg::PIX_W-1:0]  pixel,
  input  wire logic                       frame_start,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rgm_pkg::EDGE_W-1:0]      edge_value,
  output logic                            frame_end
);

  logic [rgm_pkg::GAIN_W-1:0] gain;

  logic                chain_valid [rgm_pkg::ROOT_W+1];
  logic                chain_ready [rgm_pkg::ROOT_W+1];
  rgm_pkg::sqrt_word_t chain_word  [rgm_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= rgm_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      gain <= cfg_data;
    end
  end

  rgm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (chain_valid[0]),
    .out_ready   (chain_ready[0]),
    .out_word    (chain_word[0])
  );

  for (genvar i = 0; i < rgm_pkg::ROOT_W; i++) begin : g_cell
    rgm_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  rgm_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[rgm_pkg::ROOT_W]),
    .in_ready   (chain_ready[rgm_pkg::ROOT_W]),
    .in_word    (chain_word[rgm_pkg::ROOT_W]),
    .gain       (gain),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_value (edge_value),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire
